// ===== rtl/core/sgaa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgaa_pkg
// Shared types, widths and codes of the stillness-gated accelerometer
// averager: register map, function and status codes, divider handshake.
// ----------------------------------------------------------------------------
package sgaa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_RUN     = 64;

    localparam int RUN_W       = $clog2(MAX_RUN + 1);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_RUN);
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int MAG_W       = PROD_W + 2;
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam int MAG_CFG_W   = 32;
    localparam int DRIFT_W     = 16;
    localparam int NEED_W      = 7;
    localparam int POLL_W      = 16;

    localparam int CFG_AW      = 5;
    localparam int CFG_DW      = 32;

    localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * SAMPLE_BITS + RUN_W + 7) / 8) * 8;

    localparam logic [MAG_CFG_W-1:0] MIN_MAG_RST = MAG_CFG_W'(12121538);
    localparam logic [MAG_CFG_W-1:0] MAX_MAG_RST = MAG_CFG_W'(22188868);
    localparam logic [DRIFT_W-1:0]   DRIFT_RST   = DRIFT_W'(492);
    localparam logic [NEED_W-1:0]    NEED_RST    = NEED_W'(12);
    localparam logic [POLL_W-1:0]    BUDGET_RST  = POLL_W'(600);

    typedef enum logic [2:0] {
        REG_MIN_MAG = 3'd0,
        REG_MAX_MAG = 3'd1,
        REG_DRIFT   = 3'd2,
        REG_NEED    = 3'd3,
        REG_BUDGET  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        FN_SAMPLE = 2'd0,
        FN_POLL   = 2'd1,
        FN_START  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_WAIT    = 2'd1,
        ST_DONE    = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef struct packed {
        logic [MAG_CFG_W-1:0] min_mag;
        logic [MAG_CFG_W-1:0] max_mag;
        logic [DRIFT_W-1:0]   drift;
        logic [NEED_W-1:0]    need;
        logic [POLL_W-1:0]    budget;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [RUN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/core/sgaa_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgaa_cfg
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module sgaa_cfg import sgaa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx   = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_mag <= MIN_MAG_RST;
            r_cfg.max_mag <= MAX_MAG_RST;
            r_cfg.drift   <= DRIFT_RST;
            r_cfg.need    <= NEED_RST;
            r_cfg.budget  <= BUDGET_RST;
        end else if (wr_en) begin
            case (idx)
                REG_MIN_MAG: r_cfg.min_mag <= pwdata[MAG_CFG_W-1:0];
                REG_MAX_MAG: r_cfg.max_mag <= pwdata[MAG_CFG_W-1:0];
                REG_DRIFT:   r_cfg.drift   <= pwdata[DRIFT_W-1:0];
                REG_NEED:    r_cfg.need    <= pwdata[NEED_W-1:0];
                REG_BUDGET:  r_cfg.budget  <= pwdata[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MIN_MAG: prdata = CFG_DW'(r_cfg.min_mag);
            REG_MAX_MAG: prdata = CFG_DW'(r_cfg.max_mag);
            REG_DRIFT:   prdata = CFG_DW'(r_cfg.drift);
            REG_NEED:    prdata = CFG_DW'(r_cfg.need);
            REG_BUDGET:  prdata = CFG_DW'(r_cfg.budget);
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/sgaa_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgaa_div
// Serial restoring divider, one quotient bit per cycle, unsigned sum by
// run length.
// ----------------------------------------------------------------------------
module sgaa_div import sgaa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [RUN_W-1:0]     r_den;
    logic [RUN_W-1:0]     r_rem;

    logic [RUN_W:0]       trial;
    logic [RUN_W:0]       diff;
    logic                 q_bit;

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign q_bit = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= q_bit ? diff[RUN_W-1:0] : trial[RUN_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], q_bit};
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

// ===== rtl/core/stillness_gated_accel_averager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stillness_gated_accel_averager
// Waits for a still window of three-axis accelerometer samples and reports
// its per-axis average, with a poll budget for timeout.
// ----------------------------------------------------------------------------
// One word in gives one word out. A start word opens a capture; each later
// poll word either carries a sample or reports none. A sample whose squared
// magnitude leaves the [min, max] band, or that drifts from the first sample
// of the run by more than drift_limit on any axis, restarts the run. After
// run_needed samples in a row the per-axis averages (truncated toward zero)
// come out with status done; once poll_budget polls are used, timeout. The
// block takes one word at a time and s_tready is low while it works. A sample
// goes through three squarings on one shared multiplier, a band check, three
// drift compares through one subtractor, and the accumulate. A sample that
// finishes the capture adds three passes of a one-bit-per-cycle divider,
// one per axis. A finished result waits in the output register, so the next
// word is taken while it is still pending.
// ----------------------------------------------------------------------------
module stillness_gated_accel_averager import sgaa_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z
    input  wire logic [1:0]             s_tuser,   // func
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // avg_x, avg_y, avg_z, run_length
    output logic      [1:0]             m_tuser,   // status
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_AW-1:0]      paddr,
    input  wire logic [CFG_DW-1:0]      pwdata,
    output logic      [CFG_DW-1:0]      prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_MCHK,
        S_DRIFT,
        S_ACC,
        S_FIN,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } t_state;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_state                         r_state;
    logic                           r_phase;
    logic [RUN_W-1:0]               r_run_count;
    logic [POLL_W-1:0]              r_polls_used;
    logic [1:0]                     r_idx;
    logic signed [SAMPLE_BITS-1:0]  r_smp [3];
    logic signed [SAMPLE_BITS-1:0]  r_ref [3];
    logic signed [SUM_W-1:0]        r_sum [3];
    logic signed [PROD_W-1:0]       r_prod;
    logic [MAG_W-1:0]               r_mag;
    t_status                        r_res_status;
    logic [SAMPLE_BITS-1:0]         r_res_avg [3];
    logic [RUN_W-1:0]               r_res_runlen;
    logic                           r_out_valid;
    t_status                        r_out_status;
    logic [SAMPLE_BITS-1:0]         r_out_avg [3];
    logic [RUN_W-1:0]               r_out_runlen;

    logic signed [SAMPLE_BITS-1:0]  cur_smp;
    logic signed [SAMPLE_BITS-1:0]  cur_ref;
    logic signed [PROD_W-1:0]       sq;
    logic [MAG_W-1:0]               mag_total;
    logic                           mag_bad;
    logic signed [SAMPLE_BITS:0]    diff;
    logic [SAMPLE_BITS:0]           abs_diff;
    logic                           drift_bad;
    logic [RUN_W-1:0]               need;
    logic [RUN_W-1:0]               cnt_inc;
    logic signed [SUM_W-1:0]        cur_sum;
    logic                           sum_neg;
    logic [SUM_W-1:0]               sum_abs;
    logic [SAMPLE_BITS-1:0]         quo_lo;
    logic [SAMPLE_BITS-1:0]         avg_val;
    logic                           out_free;
    logic                           out_load;

    sgaa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    sgaa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign pready = 1'b1;

    assign cur_smp   = r_smp[r_idx];
    assign cur_ref   = r_ref[r_idx];
    assign sq        = cur_smp * cur_smp;
    assign mag_total = r_mag + MAG_W'(unsigned'(r_prod));
    assign mag_bad   = (mag_total < MAG_W'(cfg.min_mag)) || (mag_total > MAG_W'(cfg.max_mag));

    assign diff      = {cur_smp[SAMPLE_BITS-1], cur_smp} - {cur_ref[SAMPLE_BITS-1], cur_ref};
    assign abs_diff  = diff[SAMPLE_BITS] ? unsigned'(-diff) : unsigned'(diff);
    assign drift_bad = (32'(abs_diff) > 32'(cfg.drift));

    always_comb begin
        if (32'(cfg.need) < 32'd2) begin
            need = RUN_W'(2);
        end else if (32'(cfg.need) > 32'(MAX_RUN)) begin
            need = RUN_W'(MAX_RUN);
        end else begin
            need = RUN_W'(cfg.need);
        end
    end

    assign cnt_inc  = r_run_count + 1'b1;

    assign cur_sum  = r_sum[r_idx];
    assign sum_neg  = cur_sum[SUM_W-1];
    assign sum_abs  = sum_neg ? unsigned'(-cur_sum) : unsigned'(cur_sum);
    assign quo_lo   = div_rsp.quo[SAMPLE_BITS-1:0];
    assign avg_val  = sum_neg ? -quo_lo : quo_lo;

    assign div_req.start = (r_state == S_DSTART);
    assign div_req.num   = sum_abs;
    assign div_req.den   = r_run_count;

    assign out_free = !r_out_valid || m_tready;
    assign out_load = (r_state == S_OUT) && out_free;
    assign s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= 1'b0;
            r_run_count  <= '0;
            r_polls_used <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_res_avg[i] <= '0;
                        end
                        r_idx <= '0;
                        case (t_func'(s_tuser))
                            FN_START: begin
                                r_phase      <= 1'b1;
                                r_polls_used <= '0;
                                r_run_count  <= '0;
                                r_res_status <= ST_WAIT;
                                r_res_runlen <= '0;
                                r_state      <= S_OUT;
                            end
                            FN_SAMPLE, FN_POLL: begin
                                if (!r_phase) begin
                                    r_res_status <= ST_IDLE;
                                    r_res_runlen <= '0;
                                    r_state      <= S_OUT;
                                end else begin
                                    if (r_polls_used != '1) begin
                                        r_polls_used <= r_polls_used + 1'b1;
                                    end
                                    if (t_func'(s_tuser) == FN_SAMPLE) begin
                                        for (int i = 0; i < 3; i++) begin
                                            r_smp[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                                        end
                                        r_mag   <= '0;
                                        r_state <= S_SQ;
                                    end else begin
                                        r_state <= S_FIN;
                                    end
                                end
                            end
                            default: begin
                                r_res_status <= r_phase ? ST_WAIT : ST_IDLE;
                                r_res_runlen <= r_phase ? r_run_count : '0;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SQ: begin
                    r_prod <= sq;
                    if (r_idx != 2'd0) begin
                        r_mag <= mag_total;
                    end
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_MCHK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MCHK: begin
                    if (mag_bad) begin
                        r_run_count <= '0;
                        r_state     <= S_FIN;
                    end else if (r_run_count == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ref[i] <= r_smp[i];
                            r_sum[i] <= SUM_W'(r_smp[i]);
                        end
                        r_run_count <= RUN_W'(1);
                        r_state     <= S_FIN;
                    end else begin
                        r_state <= S_DRIFT;
                    end
                end
                S_DRIFT: begin
                    if (drift_bad) begin
                        r_run_count <= '0;
                        r_idx       <= '0;
                        r_state     <= S_FIN;
                    end else if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ACC: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= r_sum[i] + SUM_W'(r_smp[i]);
                    end
                    r_run_count <= cnt_inc;
                    r_state     <= (cnt_inc >= need) ? S_DSTART : S_FIN;
                end
                S_FIN: begin
                    r_res_runlen <= r_run_count;
                    if (r_polls_used >= cfg.budget) begin
                        r_res_status <= ST_TIMEOUT;
                        r_phase      <= 1'b0;
                        r_run_count  <= '0;
                    end else begin
                        r_res_status <= ST_WAIT;
                    end
                    r_state <= S_OUT;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        r_res_avg[r_idx] <= avg_val;
                        if (r_idx == 2'd2) begin
                            r_res_status <= ST_DONE;
                            r_res_runlen <= r_run_count;
                            r_phase      <= 1'b0;
                            r_run_count  <= '0;
                            r_idx        <= '0;
                            r_state      <= S_OUT;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_avg    <= r_res_avg;
                        r_out_runlen <= r_res_runlen;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_status;
    assign m_tdata  = OUT_TDATA_W'({r_out_runlen, r_out_avg[2], r_out_avg[1], r_out_avg[0]});

`ifndef SYNTH
    a_run_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_count <= RUN_W'(MAX_RUN))
        else $error("run count above its cap");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == ST_DONE) |-> m_tdata[3*SAMPLE_BITS +: RUN_W] >= RUN_W'(2))
        else $error("done word with a run shorter than two");

    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != ST_DONE) |-> m_tdata[3*SAMPLE_BITS-1:0] == '0)
        else $error("nonzero average on a word that is not done");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");
`endif

endmodule
`default_nettype wire
